// File: rtl/min_weight_cycle_finder_defines.svh
// ----------------------------------------------------------------------------
// Minimum weight cycle finder assertion macros
// Shared property macros for the port checker, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef MIN_WEIGHT_CYCLE_FINDER_DEFINES_SVH
`define MIN_WEIGHT_CYCLE_FINDER_DEFINES_SVH

// Implication in the same cycle, off during reset.
`define MWCF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mwcf check failed");

// Implication in the next cycle, off during reset.
`define MWCF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mwcf check failed");

// Implication in the next cycle, also checked while reset is high.
`define MWCF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("mwcf check failed");

`endif

// File: rtl/mwcf_pkg.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder package
// Operation codes, output limits and the result record of the sequencer.
// ----------------------------------------------------------------------------
package mwcf_pkg;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   localparam int OUT_BITS = 15;
   localparam logic [OUT_BITS-1:0] OUT_MAX = 15'h7FFF;
   localparam logic [7:0] VCOUNT_RESET = 8'd128;

   typedef struct packed {
      logic                valid;
      logic                found;
      logic [OUT_BITS-1:0] weight;
   } result_type;

endpackage

// File: rtl/min_weight_cycle_finder.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder
// Stores an undirected weighted graph and reports its lightest cycle.
// ----------------------------------------------------------------------------
//   Channel   Direction   Carries
//   req_*     in          one operation: load edge, compute, clear
//   rsp_*     out         one result for each compute transaction
//   csr_*     in          vertex_count register write
//
// A load writes the two mirrored matrix entries, from S_IDLE and S_LOAD2.
// A clear sweeps the weight RAM, 2^(2*ceil(log2(MAX_VERTICES))) entries, one
// entry a cycle. The same sweep runs after reset before the first transaction
// is accepted. A compute runs one Dijkstra search per stored edge; each
// search step scans and relaxes n vertices through the distance RAM port.
// The result waits in an output register while rsp_tready is low.
// ----------------------------------------------------------------------------
module min_weight_cycle_finder import mwcf_pkg::*; #(
   parameter int MAX_VERTICES = 128,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // vertex_a, vertex_b, edge_weight
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // min_cycle_weight
   output logic        rsp_tuser,   // cycle_found
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int DW  = WEIGHT_BITS + VW;
   localparam int MAW = 2 * VW;

   logic [7:0]             vcount_ff;
   logic                   rsp_valid_ff;
   logic [OUT_BITS-1:0]    rsp_weight_ff;
   logic                   rsp_found_ff;
   logic                   take;
   result_type             result;

   logic                   m_we;
   logic [MAW-1:0]         m_waddr, m_raddr;
   logic [WEIGHT_BITS-1:0] m_wdata, m_rdata;
   logic                   d_we;
   logic [VW-1:0]          d_waddr, d_raddr;
   logic [DW-1:0]          d_wdata, d_rdata;

   assign take = !rsp_valid_ff || rsp_tready;

   mwcf_seq #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tuser),
      .req_a        (req_tdata[6:0]),
      .req_b        (req_tdata[13:7]),
      .req_w        (req_tdata[21:14]),
      .vertex_count (vcount_ff),
      .m_we         (m_we),
      .m_waddr      (m_waddr),
      .m_wdata      (m_wdata),
      .m_raddr      (m_raddr),
      .m_rdata      (m_rdata),
      .d_we         (d_we),
      .d_waddr      (d_waddr),
      .d_wdata      (d_wdata),
      .d_raddr      (d_raddr),
      .d_rdata      (d_rdata),
      .result       (result),
      .result_take  (take)
   );

   mwcf_ram #(
      .DEPTH (1 << MAW),
      .WIDTH (WEIGHT_BITS)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   mwcf_ram #(
      .DEPTH (1 << VW),
      .WIDTH (DW)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (d_we),
      .wr_addr (d_waddr),
      .wr_data (d_wdata),
      .rd_addr (d_raddr),
      .rd_data (d_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (take) begin
            rsp_valid_ff <= result.valid;
         end
      end
      if (take && result.valid) begin
         rsp_weight_ff <= result.weight;
         rsp_found_ff  <= result.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_weight_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

// File: rtl/mwcf_ram.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder RAM
// Simple dual port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mwcf_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mwcf_seq.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder sequencer
// Loads and clears the weight matrix and runs one Dijkstra search per edge.
// ----------------------------------------------------------------------------
module mwcf_seq import mwcf_pkg::*; #(
   parameter int MAX_VERTICES = 128,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_op,
   input  logic [6:0]                             req_a,
   input  logic [6:0]                             req_b,
   input  logic [7:0]                             req_w,
   input  logic [7:0]                             vertex_count,
   output logic                                   m_we,
   output logic [2*$clog2(MAX_VERTICES)-1:0]      m_waddr,
   output logic [WEIGHT_BITS-1:0]                 m_wdata,
   output logic [2*$clog2(MAX_VERTICES)-1:0]      m_raddr,
   input  logic [WEIGHT_BITS-1:0]                 m_rdata,
   output logic                                   d_we,
   output logic [$clog2(MAX_VERTICES)-1:0]        d_waddr,
   output logic [WEIGHT_BITS+$clog2(MAX_VERTICES)-1:0] d_wdata,
   output logic [$clog2(MAX_VERTICES)-1:0]        d_raddr,
   input  logic [WEIGHT_BITS+$clog2(MAX_VERTICES)-1:0] d_rdata,
   output result_type                             result,
   input  logic                                   result_take
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = VW + 1;
   localparam int DW  = WEIGHT_BITS + VW;
   localparam int MAW = 2 * VW;
   localparam int WIN = (WEIGHT_BITS < 8) ? WEIGHT_BITS : 8;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOAD2, S_EDGE_RD, S_EDGE_CHK, S_SCAN, S_SCAN_END,
      S_SCAN_DEC, S_RELAX, S_RELAX_END, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [MAW-1:0]          clr_ff, clr_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [VW-1:0]           i_ff, i_in, k_ff, k_in;
   logic [VW-1:0]           idx_ff, idx_in, pidx_ff, pidx_in, near_ff, near_in;
   logic                    pv_ff, pv_in, any_ff, any_in, best_ok_ff, best_ok_in;
   logic [DW-1:0]           nd_ff, nd_in, best_ff, best_in;
   logic [WEIGHT_BITS-1:0]  ew_ff, ew_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in, reached_ff, reached_in;

   logic [WEIGHT_BITS-1:0]  w_new;
   logic [VW-1:0]           a_idx, b_idx;
   logic                    in_range, idx_last, take_v, skip, upd;
   logic [CW-1:0]           n_new, adv_k, adv_i2;
   logic [DW-1:0]           cand, tot;
   state_type               adv_state;
   logic [VW-1:0]           adv_i_val, adv_k_val;

   assign w_new    = WEIGHT_BITS'(req_w[WIN-1:0]);
   assign a_idx    = VW'(req_a);
   assign b_idx    = VW'(req_b);
   assign in_range = (int'(req_a) < MAX_VERTICES) && (int'(req_b) < MAX_VERTICES);
   assign n_new    = (int'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                        : CW'(vertex_count);
   assign idx_last = (({1'b0, idx_ff}) + CW'(1)) == n_ff;
   assign take_v   = !visited_ff[pidx_ff] && reached_ff[pidx_ff] &&
                     (!any_ff || (d_rdata < nd_ff));
   assign skip     = (m_rdata == '0) || ((near_ff == i_ff) && (pidx_ff == k_ff)) ||
                     ((near_ff == k_ff) && (pidx_ff == i_ff));
   assign cand     = nd_ff + DW'(m_rdata);
   assign upd      = !skip && (!reached_ff[pidx_ff] || (cand < d_rdata));
   assign tot      = nd_ff + DW'(ew_ff);
   assign adv_k    = {1'b0, k_ff} + CW'(1);
   assign adv_i2   = {1'b0, i_ff} + CW'(2);

   always_comb begin
      adv_i_val = i_ff;
      adv_k_val = k_ff;
      adv_state = S_DONE;
      if (adv_k < n_ff) begin
         adv_k_val = VW'(adv_k);
         adv_state = S_EDGE_RD;
      end else if (adv_i2 < n_ff) begin
         adv_i_val = i_ff + VW'(1);
         adv_k_val = VW'(adv_i2);
         adv_state = S_EDGE_RD;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      n_in       = n_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      idx_in     = idx_ff;
      pidx_in    = pidx_ff;
      near_in    = near_ff;
      pv_in      = pv_ff;
      any_in     = any_ff;
      best_ok_in = best_ok_ff;
      nd_in      = nd_ff;
      best_in    = best_ff;
      ew_in      = ew_ff;
      visited_in = visited_ff;
      reached_in = reached_ff;
      req_ready  = 1'b0;
      m_we       = 1'b0;
      m_waddr    = '0;
      m_wdata    = '0;
      m_raddr    = '0;
      d_we       = 1'b0;
      d_waddr    = '0;
      d_wdata    = '0;
      d_raddr    = idx_ff;
      result     = '0;

      case (state_ff)
         S_CLEAR: begin
            m_we    = 1'b1;
            m_waddr = clr_ff;
            clr_in  = clr_ff + MAW'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_LOAD: begin
                     if (in_range) begin
                        m_we     = 1'b1;
                        m_waddr  = {a_idx, b_idx};
                        m_wdata  = w_new;
                        i_in     = a_idx;
                        k_in     = b_idx;
                        ew_in    = w_new;
                        state_in = S_LOAD2;
                     end
                  end
                  OP_COMPUTE: begin
                     n_in       = n_new;
                     best_ok_in = 1'b0;
                     i_in       = '0;
                     k_in       = VW'(1);
                     state_in   = (n_new < CW'(2)) ? S_DONE : S_EDGE_RD;
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOAD2: begin
            m_we     = 1'b1;
            m_waddr  = {k_ff, i_ff};
            m_wdata  = ew_ff;
            state_in = S_IDLE;
         end
         S_EDGE_RD: begin
            m_raddr  = {i_ff, k_ff};
            state_in = S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            if (m_rdata == '0) begin
               i_in     = adv_i_val;
               k_in     = adv_k_val;
               state_in = adv_state;
            end else begin
               ew_in            = m_rdata;
               visited_in       = '0;
               reached_in       = '0;
               reached_in[i_ff] = 1'b1;
               d_we             = 1'b1;
               d_waddr          = i_ff;
               idx_in           = '0;
               any_in           = 1'b0;
               pv_in            = 1'b0;
               state_in         = S_SCAN;
            end
         end
         S_SCAN, S_SCAN_END: begin
            if (pv_ff && take_v) begin
               any_in  = 1'b1;
               near_in = pidx_ff;
               nd_in   = d_rdata;
            end
            if (state_ff == S_SCAN) begin
               pv_in   = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + VW'(1);
               if (idx_last) begin
                  state_in = S_SCAN_END;
               end
            end else begin
               pv_in    = 1'b0;
               state_in = S_SCAN_DEC;
            end
         end
         S_SCAN_DEC: begin
            if (!any_ff) begin
               i_in     = adv_i_val;
               k_in     = adv_k_val;
               state_in = adv_state;
            end else begin
               visited_in[near_ff] = 1'b1;
               if (near_ff == k_ff) begin
                  if (!best_ok_ff || (tot < best_ff)) begin
                     best_in    = tot;
                     best_ok_in = 1'b1;
                  end
                  i_in     = adv_i_val;
                  k_in     = adv_k_val;
                  state_in = adv_state;
               end else if (best_ok_ff && (nd_ff > best_ff)) begin
                  i_in     = adv_i_val;
                  k_in     = adv_k_val;
                  state_in = adv_state;
               end else begin
                  idx_in   = '0;
                  pv_in    = 1'b0;
                  state_in = S_RELAX;
               end
            end
         end
         S_RELAX, S_RELAX_END: begin
            if (pv_ff && upd) begin
               d_we                = 1'b1;
               d_waddr             = pidx_ff;
               d_wdata             = cand;
               reached_in[pidx_ff] = 1'b1;
            end
            if (state_ff == S_RELAX) begin
               m_raddr = {near_ff, idx_ff};
               pv_in   = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + VW'(1);
               if (idx_last) begin
                  state_in = S_RELAX_END;
               end
            end else begin
               pv_in    = 1'b0;
               idx_in   = '0;
               any_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            result.valid = 1'b1;
            result.found = best_ok_ff;
            if (best_ok_ff) begin
               result.weight = (32'(best_ff) > 32'(OUT_MAX)) ? OUT_MAX
                                                             : OUT_BITS'(best_ff);
            end
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pv_ff    <= pv_in;
      end
      n_ff       <= n_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      idx_ff     <= idx_in;
      pidx_ff    <= pidx_in;
      near_ff    <= near_in;
      any_ff     <= any_in;
      best_ok_ff <= best_ok_in;
      nd_ff      <= nd_in;
      best_ff    <= best_in;
      ew_ff      <= ew_in;
      visited_ff <= visited_in;
      reached_ff <= reached_in;
   end

endmodule

// File: rtl/mwcf_checker.sv
// ----------------------------------------------------------------------------
// Minimum weight cycle finder port checker
// Watches the top level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "min_weight_cycle_finder_defines.svh"

module mwcf_checker import mwcf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   `MWCF_ASSERT_NEXT_ALWAYS(a_no_rsp_after_reset, reset, !rsp_tvalid)

   `MWCF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   `MWCF_ASSERT_NOW(a_none_is_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 16'd0)

   `MWCF_ASSERT_NOW(a_found_nonzero, rsp_tvalid && rsp_tuser, rsp_tdata != 16'd0)

   `MWCF_ASSERT_NEXT(a_busy_after_op, req_tvalid && req_tready && (req_tuser != OP_NOP), !req_tready)

endmodule

bind min_weight_cycle_finder mwcf_checker u_checker (.*);

// File: sim/min_weight_cycle_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Minimum weight cycle finder testbench
// Loads random graphs edge by edge under several vertex counts. Each compute
// transaction is predicted by a Dijkstra search that runs for every stored edge
// with that edge taken out. Both stream sides idle at random unless no_idle is
// set; each result is checked against the oldest predicted weight and flag.
// ----------------------------------------------------------------------------
module min_weight_cycle_finder_tb import mwcf_pkg::*;;

   localparam int NV = 128;
   localparam int unsigned NONE = 32'hFFFFFFFF;
   localparam int LIMIT = 40000000;

   class cycle_scoreboard;
      logic [7:0] adj [NV][NV];
      int unsigned vcount;
      int errors;
      logic [15:0] want_weight [$];
      logic        want_found [$];

      function new();
         foreach (adj[i, j]) adj[i][j] = 8'd0;
         vcount = 32'(VCOUNT_RESET);
         errors = 0;
      endfunction

      function void set_vcount(logic [7:0] v);
         vcount = 32'(v);
      endfunction

      function int unsigned shortest(int n, int src, int dst, int unsigned best);
         int unsigned path_len [NV];
         bit seen [NV];
         bit reach [NV];
         bit any;
         int near;
         int unsigned nd, c;
         for (int v = 0; v < n; v++) begin
            seen[v] = 0;
            reach[v] = 0;
            path_len[v] = 0;
         end
         reach[src] = 1;
         forever begin
            any = 0;
            near = 0;
            nd = 0;
            for (int v = 0; v < n; v++) begin
               if (!seen[v] && reach[v] && (!any || path_len[v] < nd)) begin
                  any = 1;
                  near = v;
                  nd = path_len[v];
               end
            end
            if (!any) return NONE;
            seen[near] = 1;
            if (near == dst) return nd;
            if (best != NONE && nd > best) return NONE;
            for (int j = 0; j < n; j++) begin
               if (adj[near][j] == 0) continue;
               if ((near == src && j == dst) || (near == dst && j == src)) continue;
               c = nd + adj[near][j];
               if (!reach[j] || c < path_len[j]) begin
                  reach[j] = 1;
                  path_len[j] = c;
               end
            end
         end
      endfunction

      function void note(logic [1:0] op, logic [6:0] a, logic [6:0] b, logic [7:0] w);
         int n;
         int unsigned best, d;
         case (op)
            OP_LOAD: begin
               adj[a][b] = w;
               adj[b][a] = w;
            end
            OP_CLEAR: begin
               foreach (adj[i, j]) adj[i][j] = 8'd0;
            end
            OP_COMPUTE: begin
               n = (vcount > NV) ? NV : vcount;
               best = NONE;
               for (int i = 0; i < n; i++) begin
                  for (int k = i + 1; k < n; k++) begin
                     if (adj[i][k] == 0) continue;
                     d = shortest(n, i, k, best);
                     if (d != NONE && (best == NONE || d + adj[i][k] < best))
                        best = d + adj[i][k];
                  end
               end
               if (best == NONE) begin
                  want_weight.push_back(16'd0);
                  want_found.push_back(1'b0);
               end else begin
                  want_weight.push_back({1'b0, (best > OUT_MAX) ? OUT_MAX : best[14:0]});
                  want_found.push_back(1'b1);
               end
            end
            default: ;
         endcase
      endfunction

      function void check(logic [15:0] weight, logic found);
         logic [15:0] ew;
         logic ef;
         if (want_weight.size() == 0) begin
            $display("%0t: unexpected result weight=%0d found=%0b", $time, weight, found);
            errors++;
            return;
         end
         ew = want_weight.pop_front();
         ef = want_found.pop_front();
         if (weight !== ew) begin
            $display("%0t: min_cycle_weight expected %0d actual %0d", $time, ew, weight);
            errors++;
         end
         if (found !== ef) begin
            $display("%0t: cycle_found expected %0b actual %0b", $time, ef, found);
            errors++;
         end
      endfunction

      function int pending();
         return want_weight.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 0;
   logic [7:0]  csr_wr_data = '0;

   cycle_scoreboard sb = new();
   int cycles = 0;
   bit no_idle = 0;

   min_weight_cycle_finder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[min_weight_cycle_finder] ERROR");
         $finish;
      end
   end

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int g;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
         g = gap_len();
         rsp_tready <= (g == 0);
         @(posedge clock);
      end
   end

   task automatic send(logic [1:0] op, logic [6:0] a, logic [6:0] b, logic [7:0] w);
      int g;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, w, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note(op, a, b, w);
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_vcount(logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_vcount(v);
      @(posedge clock);
   endtask

   initial begin
      logic [7:0] settings [12] = '{8'd8, 8'd6, 8'd128, 8'd1, 8'd0, 8'd255,
                                    8'd5, 8'd8, 8'd3, 8'd10, 8'd2, 8'd7};
      int span, r, cprob;
      logic [6:0] a, b;
      logic [7:0] w;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
      send(OP_LOAD, 7'd0, 7'd1, 8'd1);
      send(OP_LOAD, 7'd1, 7'd2, 8'd2);
      send(OP_LOAD, 7'd2, 7'd0, 8'd3);
      send(OP_LOAD, 7'd5, 7'd5, 8'd9);
      send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
      send(OP_LOAD, 7'd1, 7'd0, 8'd200);
      send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
      send(OP_LOAD, 7'd0, 7'd1, 8'd0);
      send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
      send(OP_LOAD, 7'd127, 7'd126, 8'd255);
      send(OP_LOAD, 7'd126, 7'd125, 8'd255);
      send(OP_LOAD, 7'd125, 7'd127, 8'd255);
      send(OP_NOP, 7'd127, 7'd127, 8'd255);
      send(OP_COMPUTE, 7'h7F, 7'h7F, 8'hFF);
      send(OP_CLEAR, 7'd0, 7'd0, 8'd0);
      send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
      drain();

      for (int p = 0; p < 12; p++) begin
         no_idle = (p % 4 == 3);
         write_vcount(settings[p]);
         span = (settings[p] == 0) ? 4 : (settings[p] > 8) ? 8 : settings[p];
         if (span < 2) span = 3;
         cprob = (settings[p] > 16) ? 3 : 12;
         send(OP_CLEAR, 7'd0, 7'd0, 8'd0);
         for (int i = 0; i < 140; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
               a = 7'($urandom_range(0, 127));
               b = 7'($urandom_range(0, 127));
            end else begin
               a = 7'($urandom_range(0, span - 1));
               b = 7'($urandom_range(0, span - 1));
            end
            w = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (r < cprob) send(OP_COMPUTE, a, b, w);
            else if (r < cprob + 1) send(OP_CLEAR, a, b, w);
            else if (r < cprob + 3) send(OP_NOP, a, b, w);
            else send(OP_LOAD, a, b, w);
         end
         send(OP_COMPUTE, 7'd0, 7'd0, 8'd0);
         drain();
      end

      repeat (100) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d results never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) $display("[min_weight_cycle_finder] OK");
      else $display("[min_weight_cycle_finder] ERROR");
      $finish;
   end

endmodule
